/* rtl/ps2_mouse_packet_tracker_assert.svh */
// Assertion macros for the PS/2 mouse packet tracker checker.
`ifndef PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH
`define PS2_MOUSE_PACKET_TRACKER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define PS2MT_ASSERT_SAME(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("ps2mt check failed");

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define PS2MT_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ps2mt check failed");

`endif

/* rtl/ps2mt_pkg.sv */
// Types and constants for the PS/2 mouse packet tracker.
`timescale 1ns / 1ps
package ps2mt_pkg;
	localparam int BYTE_W      = 8;
	localparam int GAIN_W      = 16;
	localparam int BOUND_W     = 13;
	localparam int STEP_W      = 17;
	localparam int BTN_W       = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int FLAG_KEEP_W = 6;

	// flags byte layout
	localparam int FLAG_VALID_BIT = 3;
	localparam int FLAG_XSIGN_BIT = 4;
	localparam int FLAG_YSIGN_BIT = 5;

	// delta is 9 bits signed; negated Y needs one more bit
	localparam int DELTA_W = 10;
	localparam int MULT_W  = DELTA_W + GAIN_W + 1;

	localparam logic [STEP_W-2:0] STEP_MAX = '1;

	localparam logic [GAIN_W-1:0]  GAIN_RESET   = 16'd512;
	localparam logic [BOUND_W-1:0] WIDTH_RESET  = 13'd640;
	localparam logic [BOUND_W-1:0] HEIGHT_RESET = 13'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_X_GAIN        = 3'd0,
		REG_Y_GAIN        = 3'd1,
		REG_SCREEN_WIDTH  = 3'd2,
		REG_SCREEN_HEIGHT = 3'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BYTE_FLAGS = 2'd0,
		BYTE_X     = 2'd1,
		BYTE_Y     = 2'd2
	} byte_pos_t;

	typedef struct packed {
		logic cap_flags;
		logic cap_x;
		logic pkt_done;
	} byte_ctl_t;
endpackage

/* rtl/ps2_mouse_packet_tracker.sv */
// Top level of the PS/2 mouse packet tracker: byte framing, scaling, cursor update.
`timescale 1ns / 1ps
// Usage
//   Input channel (in_valid / in_stall / data_byte): raw mouse bytes, grouped
//   in threes as flags, X, Y. A packet whose flags byte has bit 3 clear is
//   dropped and gives no result item.
//   Output channel (out_valid / out_stall / pos_*, button_bits, step_*): one
//   item per kept packet: clamped cursor, buttons, scaled signed steps.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): gains and
//   screen bounds; cfg_ready is always high, writes to index 4..7 are dropped.
//   Write config only while no packet is in flight.
// Timing
//   The Y byte is accepted into the packet register; the result item is shown
//   once it moves on into the result register. One byte is taken every cycle
//   while in_stall is low; the single 10x17 multiply per axis plus the position
//   add and clamp sit between the packet register and the result register.
// Reset
//   Gains 2.0, screen 640x480, cursor at screen center, byte framing at flags.
// Stall
//   A valid result register holds while out_stall is high. A following packet may
//   wait in the packet register; in_stall rises only when both are full.
module ps2_mouse_packet_tracker
	import ps2mt_pkg::*;
#(
	parameter int POS_BITS       = 12,
	parameter int GAIN_FRAC_BITS = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [BYTE_W-1:0]        data_byte,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [POS_BITS-1:0]      pos_x,
	output logic [POS_BITS-1:0]      pos_y,
	output logic [BTN_W-1:0]         button_bits,
	output logic signed [STEP_W-1:0] step_x,
	output logic signed [STEP_W-1:0] step_y,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_data
);
	localparam int BASE_W = POS_BITS + GAIN_FRAC_BITS;
	localparam int SUM_W  = ((BASE_W > MULT_W) ? BASE_W : MULT_W) + 1;
	localparam int P_W    = SUM_W - GAIN_FRAC_BITS;
	localparam int CMP_W  = ((BOUND_W > POS_BITS) ? BOUND_W : POS_BITS) + 1;
	localparam logic [POS_BITS-1:0] POS_MAX     = '1;
	localparam logic [POS_BITS-1:0] CUR_X_RESET = POS_BITS'(WIDTH_RESET >> 1);
	localparam logic [POS_BITS-1:0] CUR_Y_RESET = POS_BITS'(HEIGHT_RESET >> 1);

	// scaled step: magnitude shifted down (toward zero), saturated
	function automatic logic signed [STEP_W-1:0] scale_step(
		input logic signed [MULT_W-1:0] prod
	);
		logic [MULT_W-1:0]   mag;
		logic [MULT_W-1:0]   mag_sh;
		logic [STEP_W-2:0]   sat;
		logic [STEP_W-1:0]   res;
		mag    = prod[MULT_W-1] ? MULT_W'(-prod) : MULT_W'(prod);
		mag_sh = mag >> GAIN_FRAC_BITS;
		sat    = (mag_sh > MULT_W'(STEP_MAX)) ? STEP_MAX : mag_sh[STEP_W-2:0];
		res    = {1'b0, sat};
		return prod[MULT_W-1] ? $signed(-res) : $signed(res);
	endfunction

	// new position: floor of (cur.frac + prod), clamped to 0..limit
	function automatic logic [POS_BITS-1:0] move_axis(
		input logic [POS_BITS-1:0]      cur,
		input logic signed [MULT_W-1:0] prod,
		input logic [BOUND_W-1:0]       bound
	);
		logic signed [SUM_W-1:0] base;
		logic signed [SUM_W-1:0] sum;
		logic [P_W-1:0]          p;
		logic [CMP_W-1:0]        bound_m1;
		logic [POS_BITS-1:0]     lim;
		base     = $signed(SUM_W'({cur, {GAIN_FRAC_BITS{1'b0}}}));
		sum      = base + SUM_W'(prod);
		p        = sum[SUM_W-1:GAIN_FRAC_BITS];
		bound_m1 = CMP_W'(bound) - CMP_W'(1);
		if (bound != '0 && bound_m1 < CMP_W'(POS_MAX))
			lim = bound_m1[POS_BITS-1:0];
		else
			lim = POS_MAX;
		if (sum[SUM_W-1])
			return '0;
		else if (p > P_W'(lim))
			return lim;
		else
			return p[POS_BITS-1:0];
	endfunction

	// config registers
	logic [GAIN_W-1:0]  x_gain_q, y_gain_q;
	logic [BOUND_W-1:0] width_q, height_q;

	// byte framing
	byte_pos_t   byte_pos_q, byte_pos_d;
	byte_ctl_t   byte_ctl;
	logic        in_fire;
	logic [FLAG_KEEP_W-1:0] flags_q;
	logic [BYTE_W-1:0]      x_byte_q;

	// packet register
	logic                   pkt_valid_s1;
	logic [FLAG_KEEP_W-1:0] flags_s1;
	logic [BYTE_W-1:0]      x_byte_s1, y_byte_s1;
	logic                   s1_move;

	// result register
	logic                     out_valid_q;
	logic [POS_BITS-1:0]      cursor_x_q, cursor_y_q;
	logic [BTN_W-1:0]         btn_q;
	logic signed [STEP_W-1:0] step_x_q, step_y_q;

	// datapath
	logic signed [DELTA_W-1:0]  dx, dy;
	logic signed [GAIN_W:0]     gx, gy;
	logic signed [MULT_W-1:0]   px, py;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_gain_q <= GAIN_RESET;
			y_gain_q <= GAIN_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_X_GAIN:        x_gain_q <= cfg_data;
				REG_Y_GAIN:        y_gain_q <= cfg_data;
				REG_SCREEN_WIDTH:  width_q  <= cfg_data[BOUND_W-1:0];
				REG_SCREEN_HEIGHT: height_q <= cfg_data[BOUND_W-1:0];
				default: ;
			endcase
		end
	end

	// input is held only when a packet waits behind a stalled result
	assign in_stall = pkt_valid_s1 && out_valid_q && out_stall;
	assign in_fire  = in_valid && !in_stall;
	assign s1_move  = pkt_valid_s1 && (!out_valid_q || !out_stall);

	// byte framing: next state
	always_comb begin
		unique case (byte_pos_q)
			BYTE_FLAGS: byte_pos_d = BYTE_X;
			BYTE_X:     byte_pos_d = BYTE_Y;
			BYTE_Y:     byte_pos_d = BYTE_FLAGS;
			default:    byte_pos_d = BYTE_X;  // stray code acts as flags position
		endcase
	end

	// byte framing: strobes
	always_comb begin
		byte_ctl = '0;
		unique case (byte_pos_q)
			BYTE_X:  byte_ctl.cap_x     = in_fire;
			BYTE_Y:  byte_ctl.pkt_done  = in_fire;
			default: byte_ctl.cap_flags = in_fire;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			byte_pos_q <= BYTE_FLAGS;
		else if (in_fire)
			byte_pos_q <= byte_pos_d;
	end

	always_ff @(posedge clk) begin
		if (byte_ctl.cap_flags)
			flags_q <= data_byte[FLAG_KEEP_W-1:0];
		if (byte_ctl.cap_x)
			x_byte_q <= data_byte;
	end

	// packet register: only kept packets enter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_s1 <= 1'b0;
		end else begin
			pkt_valid_s1 <= (byte_ctl.pkt_done && flags_q[FLAG_VALID_BIT]) ||
				(pkt_valid_s1 && !s1_move);
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ctl.pkt_done) begin
			flags_s1  <= flags_q;
			x_byte_s1 <= x_byte_q;
			y_byte_s1 <= data_byte;
		end
	end

	// 9-bit signed deltas; Y is negated
	assign dx = DELTA_W'($signed({flags_s1[FLAG_XSIGN_BIT], x_byte_s1}));
	assign dy = -DELTA_W'($signed({flags_s1[FLAG_YSIGN_BIT], y_byte_s1}));
	assign gx = $signed({1'b0, x_gain_q});
	assign gy = $signed({1'b0, y_gain_q});
	assign px = MULT_W'(dx) * MULT_W'(gx);
	assign py = MULT_W'(dy) * MULT_W'(gy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cursor_x_q  <= CUR_X_RESET;
			cursor_y_q  <= CUR_Y_RESET;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
			cursor_x_q  <= move_axis(cursor_x_q, px, width_q);
			cursor_y_q  <= move_axis(cursor_y_q, py, height_q);
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			btn_q    <= flags_s1[BTN_W-1:0];
			step_x_q <= scale_step(px);
			step_y_q <= scale_step(py);
		end
	end

	// cursor only changes when a new item loads, so it doubles as the output
	assign out_valid   = out_valid_q;
	assign pos_x       = cursor_x_q;
	assign pos_y       = cursor_y_q;
	assign button_bits = btn_q;
	assign step_x      = step_x_q;
	assign step_y      = step_y_q;
endmodule

/* rtl/ps2mt_checker.sv */
// Port-level checker for the PS/2 mouse packet tracker, with its bind.
`timescale 1ns / 1ps
`include "ps2_mouse_packet_tracker_assert.svh"
module ps2mt_checker
	import ps2mt_pkg::*;
#(
	parameter int POS_BITS = 12
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [POS_BITS-1:0]      pos_x,
	input logic [POS_BITS-1:0]      pos_y,
	input logic signed [STEP_W-1:0] step_x,
	input logic signed [STEP_W-1:0] step_y
);
	// a stalled result stays up
	`PS2MT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	// a stalled result keeps its cursor and steps
	`PS2MT_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
		$stable(pos_x) && $stable(pos_y) && $stable(step_x) && $stable(step_y))
	// input backs up only behind a stalled result
	`PS2MT_ASSERT_SAME(a_in_stall_cause, in_stall, out_valid && out_stall)
	// a fresh result follows an accepted byte
	`PS2MT_ASSERT_SAME(a_out_origin, $rose(out_valid), $past(in_valid && !in_stall, 2))
endmodule

bind ps2_mouse_packet_tracker ps2mt_checker #(.POS_BITS(POS_BITS)) u_ps2mt_checker (.*);
